// ===== rtl/kpl_pkg.sv =====
// kpl_pkg: shared widths, register indexes and command codes for the
// k-nearest point list. No dependencies.
package kpl_pkg;

    localparam int ID_BITS        = 31;
    localparam int DIST_BITS      = 50;
    localparam int ACC_BITS       = 52;
    localparam int COUNT_BITS     = 4;
    localparam int CFG_DATA_BITS  = 4;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [DIST_BITS-1:0] DIST_ONES = {DIST_BITS{1'b1}};

    localparam logic [CFG_INDEX_BITS-1:0] REG_DIMS     = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_K_IN_USE = 2'd1;

    localparam logic [1:0] DIMS_3D = 2'd3;

    typedef enum logic [1:0] {
        FUNC_QUERY = 2'd0,
        FUNC_OFFER = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_BOUND = 2'd3
    } func_t;

endpackage

// ===== rtl/kpl_ram.sv =====
// kpl_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module kpl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/kpl_dist.sv =====
// kpl_dist: squared distance unit, one axis per cycle through one multiplier.
// Depends on kpl_pkg.
module kpl_dist
    import kpl_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [COORD_BITS-1:0] px,
    input  logic signed [COORD_BITS-1:0] py,
    input  logic signed [COORD_BITS-1:0] pz,
    input  logic signed [COORD_BITS-1:0] qx,
    input  logic signed [COORD_BITS-1:0] qy,
    input  logic signed [COORD_BITS-1:0] qz,
    output logic                         done,
    output logic [DIST_BITS-1:0]         dist_sq
);

    localparam int MW = COORD_BITS + 1;

    logic                  run_reg;
    logic                  done_reg;
    logic                  sat_reg;
    logic [1:0]            step_reg;
    logic [31:0]           mag_reg;
    logic [ACC_BITS-1:0]   acc_reg;
    logic [COORD_BITS-1:0] a;
    logic [COORD_BITS-1:0] b;
    logic signed [MW-1:0]  diff;
    logic [MW-1:0]         mag;
    logic [DIST_BITS-1:0]  sq;

    always_comb
    begin
        case (step_reg)
            2'd0:    begin a = px; b = qx; end
            2'd1:    begin a = py; b = qy; end
            default: begin a = pz; b = qz; end
        endcase
        diff = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
        mag  = diff[MW-1] ? MW'(-diff) : MW'(diff);
        sq   = {25'b0, mag_reg[24:0]} * {25'b0, mag_reg[24:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            sat_reg  <= 1'b0;
            step_reg <= 2'd0;
            acc_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            sat_reg  <= 1'b0;
            step_reg <= 2'd0;
            acc_reg  <= '0;
        end
        else if (run_reg)
        begin
            if (step_reg != 2'd3)
            begin
                mag_reg <= 32'(mag);
            end
            if (step_reg != 2'd0)
            begin
                acc_reg <= acc_reg + ACC_BITS'(sq);
                sat_reg <= sat_reg | (|mag_reg[31:25]);
            end
            step_reg <= step_reg + 2'd1;
            if (step_reg == 2'd3)
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done    = done_reg;
    assign dist_sq = (sat_reg || (acc_reg > ACC_BITS'(DIST_ONES))) ? DIST_ONES
                                                                   : acc_reg[DIST_BITS-1:0];

endmodule

// ===== rtl/k_nearest_point_list.sv =====
// k_nearest_point_list: top level, command sequencer over the entry RAM.
// Depends on kpl_pkg, kpl_ram, kpl_dist.
//
//  port group       | dir | handshake              | beat
//  wr_*             | in  | wr_en                  | dims or k_in_use write
//  start/func/...   | in  | start && !busy         | one command
//  done/accepted/...| out | done, one cycle        | one result
//
// Query: recompute each kept distance, bubble-sort the list, then refresh the bound.
// Offer: distance, scan for duplicate ID and slot, shift entries down, write, bound.
// Read out: one result beat per entry. Bound: loads the new bound, one result.
// The entry RAM has one read and one write port; every entry access goes there.
// Reset is asynchronous; RAM contents are not cleared. Results cannot be held off.
module k_nearest_point_list
    import kpl_pkg::*;
#(
    parameter int MAX_POINTS = 8,
    parameter int COORD_BITS = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [CFG_INDEX_BITS-1:0]    wr_index,
    input  logic [CFG_DATA_BITS-1:0]     wr_data,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   func,
    input  logic [ID_BITS-1:0]           point_id,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_y,
    input  logic signed [COORD_BITS-1:0] coord_z,
    input  logic [DIST_BITS-1:0]         bound_value,
    output logic                         done,
    output logic                         accepted,
    output logic [COUNT_BITS-1:0]        entry_count,
    output logic                         full_res,
    output logic [DIST_BITS-1:0]         distance_bound,
    output logic [ID_BITS-1:0]           out_id,
    output logic signed [COORD_BITS-1:0] out_x,
    output logic signed [COORD_BITS-1:0] out_y,
    output logic signed [COORD_BITS-1:0] out_z,
    output logic [DIST_BITS-1:0]         out_dist2,
    output logic                         last
);

    localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int Z_LO  = DIST_BITS;
    localparam int Y_LO  = Z_LO + COORD_BITS;
    localparam int X_LO  = Y_LO + COORD_BITS;
    localparam int ID_LO = X_LO + COORD_BITS;
    localparam int EW    = ID_LO + ID_BITS;

    typedef enum logic [4:0] {
        S_IDLE, S_RESULT,
        S_Q_RD, S_Q_LOAD, S_Q_START, S_Q_WAIT,
        S_SORT_RD0, S_SORT_LD0, S_SORT_RD, S_SORT_CMP, S_SORT_END,
        S_O_START, S_O_WAIT, S_O_SCAN_RD, S_O_SCAN_USE, S_O_DECIDE,
        S_O_SHIFT_RD, S_O_SHIFT_WR, S_O_WRITE,
        S_LIMIT, S_LIMIT_USE,
        S_R_RD, S_R_EMIT
    } state_t;

    function automatic logic [CW-1:0] k_limit(input logic [CFG_DATA_BITS-1:0] k);
        logic [CW-1:0] r;
        if (k == '0)
        begin
            r = CW'(1);
        end
        else if (int'(k) > MAX_POINTS)
        begin
            r = CW'(MAX_POINTS);
        end
        else
        begin
            r = CW'(k);
        end
        return r;
    endfunction

    function automatic logic sorts_first(input logic [DIST_BITS-1:0] da,
                                         input logic [ID_BITS-1:0]   ia,
                                         input logic [DIST_BITS-1:0] db,
                                         input logic [ID_BITS-1:0]   ib);
        return (da < db) || ((da == db) && (ia < ib));
    endfunction

    state_t                       state_reg;
    logic [1:0]                   dims_reg;
    logic [CFG_DATA_BITS-1:0]     k_reg;
    logic signed [COORD_BITS-1:0] qx_reg, qy_reg, qz_reg;
    logic [DIST_BITS-1:0]         limit_reg;
    logic [CW-1:0]                total_reg;
    logic [ID_BITS-1:0]           id_reg;
    logic signed [COORD_BITS-1:0] cx_reg, cy_reg, cz_reg;
    logic [DIST_BITS-1:0]         d_reg;
    logic [CW-1:0]                pos_reg;
    logic [CW-1:0]                idx_reg;
    logic [CW-1:0]                pass_reg;
    logic [EW-1:0]                cur_reg;
    logic                         acc_reg;

    logic                         done_reg, accepted_reg, full_reg, last_reg;
    logic [COUNT_BITS-1:0]        count_reg;
    logic [DIST_BITS-1:0]         bound_reg, odist_reg;
    logic [ID_BITS-1:0]           oid_reg;
    logic [COORD_BITS-1:0]        ox_reg, oy_reg, oz_reg;

    logic [CW-1:0]                keff;
    logic [CW-1:0]                keff_m1;
    logic [CW-1:0]                idx_m1;
    logic [CW-1:0]                total_m1;
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr, ram_raddr;
    logic [EW-1:0]                ram_wdata, ram_rdata;
    logic                         dist_start, dist_done;
    logic [DIST_BITS-1:0]         dist_val;
    logic signed [COORD_BITS-1:0] px, py, pz;
    logic                         rd_first;
    logic [CW-1:0]                shift_end;

    assign keff     = k_limit(k_reg);
    assign keff_m1  = keff - 1'b1;
    assign idx_m1   = idx_reg - 1'b1;
    assign total_m1 = total_reg - 1'b1;
    assign busy     = (state_reg != S_IDLE);
    assign rd_first = sorts_first(ram_rdata[DIST_BITS-1:0], ram_rdata[ID_LO +: ID_BITS],
                                  cur_reg[DIST_BITS-1:0], cur_reg[ID_LO +: ID_BITS]);
    assign shift_end = (total_reg < keff) ? total_reg : keff_m1;

    always_comb
    begin
        ram_raddr = '0;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = cur_reg;
        case (state_reg)
            S_Q_RD, S_R_RD, S_O_SCAN_RD, S_SORT_RD:
                ram_raddr = idx_reg[AW-1:0];
            S_O_SHIFT_RD:
                ram_raddr = idx_m1[AW-1:0];
            S_LIMIT:
                ram_raddr = keff_m1[AW-1:0];
            S_Q_WAIT:
            begin
                ram_we    = dist_done;
                ram_waddr = idx_reg[AW-1:0];
                ram_wdata = {cur_reg[EW-1:DIST_BITS], dist_val};
            end
            S_O_SHIFT_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg[AW-1:0];
                ram_wdata = ram_rdata;
            end
            S_O_WRITE:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg[AW-1:0];
                ram_wdata = {id_reg, cx_reg, cy_reg, cz_reg, d_reg};
            end
            S_SORT_CMP:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_m1[AW-1:0];
                ram_wdata = rd_first ? ram_rdata : cur_reg;
            end
            S_SORT_END:
            begin
                ram_we    = 1'b1;
                ram_waddr = total_m1[AW-1:0];
                ram_wdata = cur_reg;
            end
            default:
            begin
                ram_raddr = '0;
            end
        endcase
    end

    assign dist_start = (state_reg == S_O_START) || (state_reg == S_Q_START);
    assign px = (state_reg == S_O_START || state_reg == S_O_WAIT) ? cx_reg
                                                                  : cur_reg[X_LO +: COORD_BITS];
    assign py = (state_reg == S_O_START || state_reg == S_O_WAIT) ? cy_reg
                                                                  : cur_reg[Y_LO +: COORD_BITS];
    assign pz = (state_reg == S_O_START || state_reg == S_O_WAIT) ? cz_reg
                                                                  : cur_reg[Z_LO +: COORD_BITS];

    kpl_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_POINTS)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    kpl_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (dist_start),
        .px      (px),
        .py      (py),
        .pz      (pz),
        .qx      (qx_reg),
        .qy      (qy_reg),
        .qz      (qz_reg),
        .done    (dist_done),
        .dist_sq (dist_val)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            dims_reg     <= DIMS_3D;
            k_reg        <= CFG_DATA_BITS'(8);
            qx_reg       <= '0;
            qy_reg       <= '0;
            qz_reg       <= '0;
            limit_reg    <= DIST_ONES;
            total_reg    <= '0;
            acc_reg      <= 1'b0;
            idx_reg      <= '0;
            pos_reg      <= '0;
            pass_reg     <= '0;
            done_reg     <= 1'b0;
            accepted_reg <= 1'b0;
            full_reg     <= 1'b0;
            last_reg     <= 1'b0;
            count_reg    <= '0;
            bound_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (wr_en)
            begin
                if (wr_index == REG_DIMS)
                begin
                    dims_reg <= wr_data[1:0];
                end
                else if (wr_index == REG_K_IN_USE)
                begin
                    k_reg <= wr_data;
                    if (total_reg > k_limit(wr_data))
                    begin
                        total_reg <= k_limit(wr_data);
                    end
                end
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        acc_reg <= 1'b0;
                        id_reg  <= point_id;
                        cx_reg  <= coord_x;
                        cy_reg  <= coord_y;
                        cz_reg  <= (dims_reg == DIMS_3D) ? coord_z : '0;
                        idx_reg <= '0;
                        case (func_t'(func))
                            FUNC_QUERY:
                            begin
                                qx_reg    <= coord_x;
                                qy_reg    <= coord_y;
                                qz_reg    <= (dims_reg == DIMS_3D) ? coord_z : '0;
                                state_reg <= (total_reg == '0) ? S_RESULT : S_Q_RD;
                            end
                            FUNC_OFFER:
                                state_reg <= S_O_START;
                            FUNC_READ:
                                state_reg <= (total_reg == '0) ? S_RESULT : S_R_RD;
                            default:
                            begin
                                limit_reg <= bound_value;
                                state_reg <= S_RESULT;
                            end
                        endcase
                    end
                end
                S_Q_RD:
                    state_reg <= S_Q_LOAD;
                S_Q_LOAD:
                begin
                    cur_reg   <= ram_rdata;
                    state_reg <= S_Q_START;
                end
                S_Q_START:
                    state_reg <= S_Q_WAIT;
                S_Q_WAIT:
                begin
                    if (dist_done)
                    begin
                        if (idx_reg + 1'b1 == total_reg)
                        begin
                            pass_reg  <= '0;
                            state_reg <= (total_reg > CW'(1)) ? S_SORT_RD0 : S_LIMIT;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_Q_RD;
                        end
                    end
                end
                S_SORT_RD0:
                begin
                    idx_reg   <= '0;
                    state_reg <= S_SORT_LD0;
                end
                S_SORT_LD0:
                begin
                    cur_reg   <= ram_rdata;
                    idx_reg   <= CW'(1);
                    state_reg <= S_SORT_RD;
                end
                S_SORT_RD:
                    state_reg <= S_SORT_CMP;
                S_SORT_CMP:
                begin
                    if (!rd_first)
                    begin
                        cur_reg <= ram_rdata;
                    end
                    if (idx_reg + 1'b1 == total_reg)
                    begin
                        state_reg <= S_SORT_END;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_SORT_RD;
                    end
                end
                S_SORT_END:
                begin
                    if (pass_reg + 1'b1 == total_m1)
                    begin
                        state_reg <= S_LIMIT;
                    end
                    else
                    begin
                        pass_reg  <= pass_reg + 1'b1;
                        state_reg <= S_SORT_RD0;
                    end
                end
                S_O_START:
                    state_reg <= S_O_WAIT;
                S_O_WAIT:
                begin
                    if (dist_done)
                    begin
                        d_reg   <= dist_val;
                        pos_reg <= total_reg;
                        if (dist_val > limit_reg)
                        begin
                            state_reg <= S_RESULT;
                        end
                        else if (total_reg == '0)
                        begin
                            state_reg <= S_O_DECIDE;
                        end
                        else
                        begin
                            state_reg <= S_O_SCAN_RD;
                        end
                    end
                end
                S_O_SCAN_RD:
                    state_reg <= S_O_SCAN_USE;
                S_O_SCAN_USE:
                begin
                    if (ram_rdata[ID_LO +: ID_BITS] == id_reg)
                    begin
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        if (pos_reg == total_reg &&
                            sorts_first(d_reg, id_reg, ram_rdata[DIST_BITS-1:0],
                                        ram_rdata[ID_LO +: ID_BITS]))
                        begin
                            pos_reg <= idx_reg;
                        end
                        if (idx_reg + 1'b1 == total_reg)
                        begin
                            state_reg <= S_O_DECIDE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_O_SCAN_RD;
                        end
                    end
                end
                S_O_DECIDE:
                begin
                    if (pos_reg < keff)
                    begin
                        idx_reg   <= shift_end;
                        state_reg <= (shift_end > pos_reg) ? S_O_SHIFT_RD : S_O_WRITE;
                    end
                    else
                    begin
                        state_reg <= S_LIMIT;
                    end
                end
                S_O_SHIFT_RD:
                    state_reg <= S_O_SHIFT_WR;
                S_O_SHIFT_WR:
                begin
                    if (idx_m1 == pos_reg)
                    begin
                        state_reg <= S_O_WRITE;
                    end
                    else
                    begin
                        idx_reg   <= idx_m1;
                        state_reg <= S_O_SHIFT_RD;
                    end
                end
                S_O_WRITE:
                begin
                    acc_reg <= 1'b1;
                    if (total_reg < keff)
                    begin
                        total_reg <= total_reg + 1'b1;
                    end
                    state_reg <= S_LIMIT;
                end
                S_LIMIT:
                    state_reg <= (total_reg == keff) ? S_LIMIT_USE : S_RESULT;
                S_LIMIT_USE:
                begin
                    limit_reg <= ram_rdata[DIST_BITS-1:0];
                    state_reg <= S_RESULT;
                end
                S_RESULT:
                begin
                    done_reg     <= 1'b1;
                    accepted_reg <= acc_reg;
                    count_reg    <= COUNT_BITS'(total_reg);
                    full_reg     <= (total_reg == keff);
                    bound_reg    <= limit_reg;
                    oid_reg      <= '0;
                    ox_reg       <= '0;
                    oy_reg       <= '0;
                    oz_reg       <= '0;
                    odist_reg    <= '0;
                    last_reg     <= 1'b1;
                    state_reg    <= S_IDLE;
                end
                S_R_RD:
                    state_reg <= S_R_EMIT;
                S_R_EMIT:
                begin
                    done_reg     <= 1'b1;
                    accepted_reg <= 1'b0;
                    count_reg    <= COUNT_BITS'(total_reg);
                    full_reg     <= (total_reg == keff);
                    bound_reg    <= limit_reg;
                    oid_reg      <= ram_rdata[ID_LO +: ID_BITS];
                    ox_reg       <= ram_rdata[X_LO +: COORD_BITS];
                    oy_reg       <= ram_rdata[Y_LO +: COORD_BITS];
                    oz_reg       <= ram_rdata[Z_LO +: COORD_BITS];
                    odist_reg    <= ram_rdata[DIST_BITS-1:0];
                    last_reg     <= (idx_reg + 1'b1 == total_reg);
                    idx_reg      <= idx_reg + 1'b1;
                    state_reg    <= (idx_reg + 1'b1 == total_reg) ? S_IDLE : S_R_RD;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign done           = done_reg;
    assign accepted       = accepted_reg;
    assign entry_count    = count_reg;
    assign full_res       = full_reg;
    assign distance_bound = bound_reg;
    assign out_id         = oid_reg;
    assign out_x          = ox_reg;
    assign out_y          = oy_reg;
    assign out_z          = oz_reg;
    assign out_dist2      = odist_reg;
    assign last           = last_reg;

    a_total_in_k: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= keff)
        else $error("entry count above k");

    a_more_beats: assert property (@(posedge clk) disable iff (!rst_n)
        done && !last |-> busy)
        else $error("read out stopped early");

    a_accept_single: assert property (@(posedge clk) disable iff (!rst_n)
        done && accepted |-> last)
        else $error("accepted on a read-out beat");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("command not taken");

endmodule
